FILE: src/rotated_quad_corner_generator_top_defines.svh
// Assertion macros for the quad corner generator RTL, included by rqcg_rotate.
`ifndef ROTATED_QUAD_CORNER_GENERATOR_TOP_DEFINES_SVH
`define ROTATED_QUAD_CORNER_GENERATOR_TOP_DEFINES_SVH

// Check a property on every rising edge of clk_i outside reset.
`define RQCG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define RQCG_ASSERT_NEXT(label, ante, cons, msg) \
  `RQCG_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: src/rqcg_pkg.sv
`default_nettype none

package rqcg_pkg;

  localparam int COORD_W    = 24;
  localparam int ANGLE_W    = 16;
  localparam int TURN_W     = 32;
  localparam int TRIG_W     = 32;
  localparam int TRIG_FRAC  = 28;
  localparam int ATAN_N     = 24;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int PROD_W     = DELTA_W + TRIG_W;
  localparam int ROT_W      = PROD_W - TRIG_FRAC;

  // CORDIC gain 0.6072529 in Q4.28 (32-bit signed, 28 fraction bits)
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd163008219;

  // Quadrant codes from the top two bits of the turn
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // atan(2^-i) as a fraction of a 32-bit turn
  localparam logic [TURN_W-1:0] ATAN_TURN [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic        [ANGLE_W-1:0] angle;
  } rqcg_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] bl_x;
    logic signed [COORD_W-1:0] bl_y;
    logic signed [COORD_W-1:0] br_x;
    logic signed [COORD_W-1:0] br_y;
    logic signed [COORD_W-1:0] tr_x;
    logic signed [COORD_W-1:0] tr_y;
    logic signed [COORD_W-1:0] tl_x;
    logic signed [COORD_W-1:0] tl_y;
  } rqcg_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
  } rqcg_box_t;

  typedef struct packed {
    rqcg_box_t                 box;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic        [1:0]         quad;
    logic                      bypass;
  } rqcg_side_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
  } rqcg_vec_t;

  typedef struct packed {
    rqcg_vec_t  vec;
    rqcg_side_t side;
  } rqcg_stage_t;

endpackage

`default_nettype wire

FILE: src/rqcg_cordic_stage.sv
`default_nettype none

module rqcg_cordic_stage #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire rqcg_pkg::rqcg_stage_t data_i,
  output logic                      valid_o,
  output rqcg_pkg::rqcg_stage_t      data_o
);
  import rqcg_pkg::*;

  localparam logic signed [TRIG_W-1:0] STEP_ANGLE = $signed(ATAN_TURN[IDX]);

  logic                     valid_q;
  rqcg_stage_t              data_d, data_q;
  logic signed [TRIG_W-1:0] x_shift, y_shift;

  always_comb begin
    x_shift = $signed(data_i.vec.x) >>> IDX;
    y_shift = $signed(data_i.vec.y) >>> IDX;
    data_d  = data_i;
    // rotate toward zero residual angle
    if (!data_i.vec.z[TRIG_W-1]) begin
      data_d.vec.x = data_i.vec.x - y_shift;
      data_d.vec.y = data_i.vec.y + x_shift;
      data_d.vec.z = data_i.vec.z - STEP_ANGLE;
    end else begin
      data_d.vec.x = data_i.vec.x + y_shift;
      data_d.vec.y = data_i.vec.y - x_shift;
      data_d.vec.z = data_i.vec.z + STEP_ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: src/rqcg_rotate.sv
`default_nettype none

module rqcg_rotate (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire rqcg_pkg::rqcg_stage_t data_i,
  output logic                       valid_o,
  output rqcg_pkg::rqcg_out_t        out_o
);
  import rqcg_pkg::*;

  localparam int SUM_W = ROT_W + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (TRIG_FRAC - 1);
  localparam logic signed [SUM_W-1:0]  COORD_HI   =
    SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0]  COORD_LO   = -COORD_HI - SUM_W'(1);
  localparam logic signed [TRIG_W-1:0] TRIG_LIM   = TRIG_W'(1) <<< (TRIG_FRAC + 1);

  function automatic logic signed [COORD_W-1:0] clamp_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > COORD_HI) begin
      r = COORD_HI;
    end else if (v < COORD_LO) begin
      r = COORD_LO;
    end
    return $signed(r[COORD_W-1:0]);
  endfunction

  // R1: quadrant map and corner offsets
  logic                      r1_valid_q;
  logic signed [TRIG_W-1:0]  c_d, s_d, c_q, s_q;
  logic signed [DELTA_W-1:0] dx_d [2];
  logic signed [DELTA_W-1:0] dy_d [2];
  logic signed [DELTA_W-1:0] dx_q [2];
  logic signed [DELTA_W-1:0] dy_q [2];
  rqcg_side_t                r1_side_q;

  // R2: products
  logic                      r2_valid_q;
  logic signed [PROD_W-1:0]  pxc_d [2];
  logic signed [PROD_W-1:0]  pxs_d [2];
  logic signed [PROD_W-1:0]  pyc_d [2];
  logic signed [PROD_W-1:0]  pys_d [2];
  logic signed [PROD_W-1:0]  pxc_q [2];
  logic signed [PROD_W-1:0]  pxs_q [2];
  logic signed [PROD_W-1:0]  pyc_q [2];
  logic signed [PROD_W-1:0]  pys_q [2];
  rqcg_side_t                r2_side_q;

  // R3: rounded rotated offsets per corner
  logic                      r3_valid_q;
  logic signed [ROT_W-1:0]   rx_d [4];
  logic signed [ROT_W-1:0]   ry_d [4];
  logic signed [ROT_W-1:0]   rx_q [4];
  logic signed [ROT_W-1:0]   ry_q [4];
  rqcg_side_t                r3_side_q;

  // Output register
  logic                      valid_q;
  rqcg_out_t                 out_d, out_q;

  always_comb begin
    unique case (data_i.side.quad)
      QUAD_0: begin
        c_d = data_i.vec.x;
        s_d = data_i.vec.y;
      end
      QUAD_1: begin
        c_d = -data_i.vec.y;
        s_d = data_i.vec.x;
      end
      QUAD_2: begin
        c_d = -data_i.vec.x;
        s_d = -data_i.vec.y;
      end
      QUAD_3: begin
        c_d = data_i.vec.y;
        s_d = -data_i.vec.x;
      end
      default: begin
        c_d = data_i.vec.x;
        s_d = data_i.vec.y;
      end
    endcase
    dx_d[0] = $signed({data_i.side.box.min_x[COORD_W-1], data_i.side.box.min_x})
            - $signed({data_i.side.cx[COORD_W-1], data_i.side.cx});
    dx_d[1] = $signed({data_i.side.box.max_x[COORD_W-1], data_i.side.box.max_x})
            - $signed({data_i.side.cx[COORD_W-1], data_i.side.cx});
    dy_d[0] = $signed({data_i.side.box.min_y[COORD_W-1], data_i.side.box.min_y})
            - $signed({data_i.side.cy[COORD_W-1], data_i.side.cy});
    dy_d[1] = $signed({data_i.side.box.max_y[COORD_W-1], data_i.side.box.max_y})
            - $signed({data_i.side.cy[COORD_W-1], data_i.side.cy});
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pxc_d[i] = dx_q[i] * c_q;
      pxs_d[i] = dx_q[i] * s_q;
      pyc_d[i] = dy_q[i] * c_q;
      pys_d[i] = dy_q[i] * s_q;
    end
  end

  // Corners in order bottom-left, bottom-right, top-right, top-left
  always_comb begin
    logic signed [PROD_W-1:0] sum_x;
    logic signed [PROD_W-1:0] sum_y;
    logic                     xi;
    logic                     yi;
    for (int k = 0; k < 4; k++) begin
      xi    = (k == 1 || k == 2);
      yi    = (k >= 2);
      sum_x = pxc_q[xi] - pys_q[yi] + ROUND_HALF;
      sum_y = pxs_q[xi] + pyc_q[yi] + ROUND_HALF;
      rx_d[k] = $signed(sum_x[PROD_W-1:TRIG_FRAC]);
      ry_d[k] = $signed(sum_y[PROD_W-1:TRIG_FRAC]);
    end
  end

  always_comb begin
    logic signed [COORD_W-1:0] fx [4];
    logic signed [COORD_W-1:0] fy [4];
    logic signed [SUM_W-1:0]   cx_ext;
    logic signed [SUM_W-1:0]   cy_ext;
    cx_ext = $signed({{(SUM_W-COORD_W){r3_side_q.cx[COORD_W-1]}}, r3_side_q.cx});
    cy_ext = $signed({{(SUM_W-COORD_W){r3_side_q.cy[COORD_W-1]}}, r3_side_q.cy});
    for (int k = 0; k < 4; k++) begin
      fx[k] = clamp_coord($signed({rx_q[k][ROT_W-1], rx_q[k]}) + cx_ext);
      fy[k] = clamp_coord($signed({ry_q[k][ROT_W-1], ry_q[k]}) + cy_ext);
    end
    if (r3_side_q.bypass) begin
      // zero angle: pass the box corners through untouched
      out_d.bl_x = r3_side_q.box.min_x;
      out_d.bl_y = r3_side_q.box.min_y;
      out_d.br_x = r3_side_q.box.max_x;
      out_d.br_y = r3_side_q.box.min_y;
      out_d.tr_x = r3_side_q.box.max_x;
      out_d.tr_y = r3_side_q.box.max_y;
      out_d.tl_x = r3_side_q.box.min_x;
      out_d.tl_y = r3_side_q.box.max_y;
    end else begin
      out_d.bl_x = fx[0];
      out_d.bl_y = fy[0];
      out_d.br_x = fx[1];
      out_d.br_y = fy[1];
      out_d.tr_x = fx[2];
      out_d.tr_y = fy[2];
      out_d.tl_x = fx[3];
      out_d.tl_y = fy[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
      r2_valid_q <= 1'b0;
      r3_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else if (en_i) begin
      r1_valid_q <= valid_i;
      r2_valid_q <= r1_valid_q;
      r3_valid_q <= r2_valid_q;
      valid_q    <= r3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q       <= c_d;
      s_q       <= s_d;
      dx_q      <= dx_d;
      dy_q      <= dy_d;
      r1_side_q <= data_i.side;
      pxc_q     <= pxc_d;
      pxs_q     <= pxs_d;
      pyc_q     <= pyc_d;
      pys_q     <= pys_d;
      r2_side_q <= r1_side_q;
      rx_q      <= rx_d;
      ry_q      <= ry_d;
      r3_side_q <= r2_side_q;
      out_q     <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

  logic                   trig_ok;
  logic                   pass_en;
  logic [4*COORD_W-1:0]   pass_out;
  logic [4*COORD_W-1:0]   pass_box;

  assign trig_ok  = (c_q < TRIG_LIM) && (c_q > -TRIG_LIM)
                 && (s_q < TRIG_LIM) && (s_q > -TRIG_LIM);
  assign pass_en  = en_i && r3_valid_q && r3_side_q.bypass;
  assign pass_out = {out_q.bl_x, out_q.br_y, out_q.tr_x, out_q.tl_y};
  assign pass_box = {r3_side_q.box.min_x, r3_side_q.box.min_y,
                     r3_side_q.box.max_x, r3_side_q.box.max_y};

`include "rotated_quad_corner_generator_top_defines.svh"

  `RQCG_ASSERT(cos_sin_range_a, !r1_valid_q || trig_ok, "cosine or sine out of Q2.28 range")
  `RQCG_ASSERT_NEXT(bypass_exact_a, pass_en, pass_out == $past(pass_box), "zero angle mismatch")
  `RQCG_ASSERT_NEXT(valid_advance_a, en_i, valid_q == $past(r3_valid_q), "valid lost or invented")

endmodule

`default_nettype wire

FILE: src/rotated_quad_corner_generator_top.sv
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    in_data_i  (box corners, angle)
// out      output     out_valid_o / out_stall_i  out_data_o (four rotated corners)
//
// One quad per cycle unless stalled; the stages are an input register,
// one CORDIC iteration per stage, then quadrant map, multiply, round, clamp.
// The CORDIC iteration chain sets the depth; every stage takes a new item in each
// cycle it is not frozen. Reset clears only the valid bits of the stages.
// out_stall_i with a result waiting freezes the whole pipeline and raises in_stall_o
// in the same cycle; nothing moves, nothing is dropped.
module rotated_quad_corner_generator_top #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rqcg_pkg::rqcg_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rqcg_pkg::rqcg_out_t     out_data_o
);
  import rqcg_pkg::*;

  logic                   pipe_en;
  logic                   s0_valid_q;
  rqcg_stage_t            s0_d, s0_q;
  logic signed [COORD_W:0] sum_x, sum_y;

  logic [CORDIC_STAGES:0] stage_valid;
  rqcg_stage_t            stage_data [CORDIC_STAGES+1];

  // advance everything unless a finished result is held
  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  always_comb begin
    sum_x = $signed({in_data_i.min_x[COORD_W-1], in_data_i.min_x})
          + $signed({in_data_i.max_x[COORD_W-1], in_data_i.max_x});
    sum_y = $signed({in_data_i.min_y[COORD_W-1], in_data_i.min_y})
          + $signed({in_data_i.max_y[COORD_W-1], in_data_i.max_y});
    s0_d.side.box.min_x = in_data_i.min_x;
    s0_d.side.box.min_y = in_data_i.min_y;
    s0_d.side.box.max_x = in_data_i.max_x;
    s0_d.side.box.max_y = in_data_i.max_y;
    // floor of the half sum
    s0_d.side.cx        = $signed(sum_x[COORD_W:1]);
    s0_d.side.cy        = $signed(sum_y[COORD_W:1]);
    s0_d.side.quad      = in_data_i.angle[ANGLE_W-1 -: 2];
    s0_d.side.bypass    = (in_data_i.angle == '0);
    s0_d.vec.x          = CORDIC_GAIN;
    s0_d.vec.y          = '0;
    s0_d.vec.z          = $signed({2'b00, in_data_i.angle[ANGLE_W-3:0],
                                   {(TURN_W-ANGLE_W){1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s0_q <= s0_d;
    end
  end

  assign stage_valid[0] = s0_valid_q;
  assign stage_data[0]  = s0_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    rqcg_cordic_stage #(
      .IDX(g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .valid_i(stage_valid[g]),
      .data_i (stage_data[g]),
      .valid_o(stage_valid[g+1]),
      .data_o (stage_data[g+1])
    );
  end

  rqcg_rotate u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .valid_i(stage_valid[CORDIC_STAGES]),
    .data_i (stage_data[CORDIC_STAGES]),
    .valid_o(out_valid_o),
    .out_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: test/tb_rotated_quad_corner_generator_top.sv
`timescale 1ns / 1ps

module tb_rotated_quad_corner_generator_top;
  import rqcg_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int LATENCY       = CORDIC_STAGES + 5;
  localparam int RANDOM_QUADS  = 1230;
  localparam int LONG_HOLD     = 200;
  localparam int MAX_WAIT      = 18;
  localparam int C_MAX         = (1 << (COORD_W - 1)) - 1;
  localparam int C_MIN         = -(1 << (COORD_W - 1));

  typedef struct {
    rqcg_in_t  stim;
    bit        typed;
    rqcg_out_t corners;
  } quad_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  rqcg_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  rqcg_out_t out_data_o;

  rqcg_out_t pending_corners[$];
  quad_row_t quad_table[$];
  int        fail_cnt = 0;
  bit        long_hold_req = 1'b0;
  string     field_name[8] = '{"bl_x", "bl_y", "br_x", "br_y", "tr_x", "tr_y", "tl_x", "tl_y"};

  rotated_quad_corner_generator_top #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint saturate_coord(longint v);
    if (v > C_MAX) return C_MAX;
    if (v < C_MIN) return C_MIN;
    return v;
  endfunction

  // Corners of the box, rotated about its floor-rounded center when the angle is nonzero.
  function automatic rqcg_out_t rotate_quad(rqcg_in_t q);
    logic [TURN_W-1:0] turn;
    longint x, y, z, xs, ys, c, s, cx, cy, dx, dy, rx, ry;
    longint half;
    longint px[4], py[4];
    rqcg_out_t r;
    px[0] = q.min_x; py[0] = q.min_y;
    px[1] = q.max_x; py[1] = q.min_y;
    px[2] = q.max_x; py[2] = q.max_y;
    px[3] = q.min_x; py[3] = q.max_y;
    if (q.angle != '0) begin
      turn = TURN_W'(q.angle) << (TURN_W - ANGLE_W);
      z = longint'(turn[TURN_W-3:0]);
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < CORDIC_STAGES && i < ATAN_N; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys; y = y + xs; z = z - longint'(ATAN_TURN[i]);
        end else begin
          x = x + ys; y = y - xs; z = z + longint'(ATAN_TURN[i]);
        end
      end
      case (turn[TURN_W-1 -: 2])
        QUAD_0:  begin c = x;  s = y;  end
        QUAD_1:  begin c = -y; s = x;  end
        QUAD_2:  begin c = -x; s = -y; end
        default: begin c = y;  s = -x; end
      endcase
      cx = (px[0] + px[1]) >>> 1;
      cy = (py[0] + py[2]) >>> 1;
      half = longint'(1) << (TRIG_FRAC - 1);
      for (int k = 0; k < 4; k++) begin
        dx = px[k] - cx;
        dy = py[k] - cy;
        rx = (dx * c - dy * s + half) >>> TRIG_FRAC;
        ry = (dx * s + dy * c + half) >>> TRIG_FRAC;
        px[k] = saturate_coord(rx + cx);
        py[k] = saturate_coord(ry + cy);
      end
    end
    r.bl_x = COORD_W'(px[0]); r.bl_y = COORD_W'(py[0]);
    r.br_x = COORD_W'(px[1]); r.br_y = COORD_W'(py[1]);
    r.tr_x = COORD_W'(px[2]); r.tr_y = COORD_W'(py[2]);
    r.tl_x = COORD_W'(px[3]); r.tl_y = COORD_W'(py[3]);
    return r;
  endfunction

  function automatic rqcg_in_t make_quad(int mnx, int mny, int mxx, int mxy, int ang);
    rqcg_in_t q;
    q.min_x = COORD_W'(mnx);
    q.min_y = COORD_W'(mny);
    q.max_x = COORD_W'(mxx);
    q.max_y = COORD_W'(mxy);
    q.angle = ANGLE_W'(ang);
    return q;
  endfunction

  function automatic rqcg_out_t corner_list(int blx, int bly, int brx, int bry,
                                            int trx, int try_, int tlx, int tly);
    rqcg_out_t r;
    r.bl_x = COORD_W'(blx); r.bl_y = COORD_W'(bly);
    r.br_x = COORD_W'(brx); r.br_y = COORD_W'(bry);
    r.tr_x = COORD_W'(trx); r.tr_y = COORD_W'(try_);
    r.tl_x = COORD_W'(tlx); r.tl_y = COORD_W'(tly);
    return r;
  endfunction

  function automatic int random_coord();
    int pick;
    pick = $urandom_range(0, 4);
    case (pick)
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic rqcg_in_t random_quad();
    int mode, amode, ang, cxr, cyr;
    int mnx, mny, mxx, mxy;
    mode = $urandom_range(0, 9);
    if (mode <= 4) begin
      mnx = $urandom; mny = $urandom; mxx = $urandom; mxy = $urandom;
    end else if (mode <= 7) begin
      // well-formed sprite: small box somewhere in the field range
      cxr = $urandom_range(0, 2 * C_MAX) + C_MIN;
      cyr = $urandom_range(0, 2 * C_MAX) + C_MIN;
      mnx = cxr; mny = cyr;
      mxx = cxr + $urandom_range(0, 8192);
      mxy = cyr + $urandom_range(0, 8192);
    end else if (mode == 8) begin
      mnx = random_coord(); mny = random_coord();
      mxx = random_coord(); mxy = random_coord();
    end else begin
      // swapped corners
      mxx = $urandom_range(0, 65536) - 32768;
      mxy = $urandom_range(0, 65536) - 32768;
      mnx = mxx + $urandom_range(1, 4096);
      mny = mxy + $urandom_range(1, 4096);
    end
    amode = $urandom_range(0, 7);
    case (amode)
      0:       ang = 0;
      1:       ang = $urandom_range(1, 3) << (ANGLE_W - 2);
      2:       ang = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 16)
                                                 : (1 << ANGLE_W) - $urandom_range(1, 16);
      default: ang = $urandom;
    endcase
    return make_quad(mnx, mny, mxx, mxy, ang);
  endfunction

  function automatic int draw_wait(bit burst);
    if (burst) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic add_row(rqcg_in_t stim, bit typed, rqcg_out_t corners);
    quad_row_t row;
    row.stim = stim;
    row.typed = typed;
    row.corners = corners;
    quad_table.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_quad(rqcg_in_t stim, rqcg_out_t corners, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= stim;
    do @(posedge clk_i); while (in_stall_o);
    pending_corners.push_back(corners);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_corners.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : feed_quads
    rqcg_in_t stim;
    bit       send_burst;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    send_burst = 1'b0;

    add_row(make_quad(C_MIN, C_MIN, C_MAX, C_MAX, 0), 1'b1,
            corner_list(C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX));
    add_row(make_quad(C_MAX, C_MAX, C_MIN, C_MIN, 0), 1'b1,
            corner_list(C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN));
    add_row(make_quad(0, 0, 0, 0, 0), 1'b1, corner_list(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_quad(-256, 512, 1024, -768, 0), 1'b1,
            corner_list(-256, 512, 1024, 512, 1024, -768, -256, -768));
    add_row(make_quad(-256, -256, 256, 256, 'h4000), 1'b0, '0);
    add_row(make_quad(-256, -256, 256, 256, 'h8000), 1'b0, '0);
    add_row(make_quad(-256, -256, 256, 256, 'hC000), 1'b0, '0);
    add_row(make_quad(0, 0, 2560, 1280, 'h2000), 1'b0, '0);
    add_row(make_quad(-1000, -2000, 3000, 4000, 1), 1'b0, '0);
    add_row(make_quad(-1000, -2000, 3000, 4000, 'hFFFF), 1'b0, '0);
    add_row(make_quad(1, -3, 2, 4, 'h1555), 1'b0, '0);
    add_row(make_quad(C_MIN, C_MIN, C_MAX, C_MAX, 'h2000), 1'b0, '0);
    add_row(make_quad(C_MIN, C_MIN, C_MAX, C_MAX, 'h8000), 1'b0, '0);
    add_row(make_quad(5000, 5000, -5000, -3000, 'h3000), 1'b0, '0);
    add_row(make_quad(C_MAX - 100, C_MAX - 100, C_MAX, C_MAX, 'h4000), 1'b0, '0);
    add_row(make_quad(C_MIN, C_MIN, C_MIN + 100, C_MIN + 100, 'hC000), 1'b0, '0);
    add_row(make_quad(777, 777, 777, 777, 'h5A5A), 1'b0, '0);
    add_row(make_quad(-12345, 6789, 23456, 98765, 'hAAAA), 1'b0, '0);
    add_row(make_quad(-12345, 6789, 23456, 98765, 'h5555), 1'b0, '0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (quad_table[i]) begin
      send_quad(quad_table[i].stim,
                quad_table[i].typed ? quad_table[i].corners : rotate_quad(quad_table[i].stim),
                draw_wait(1'b0));
    end

    for (int n = 0; n < RANDOM_QUADS; n++) begin
      if (n % 50 == 0) send_burst = ($urandom_range(0, 2) == 0);
      // back up the pipeline: receiver holds off while we keep offering
      if (n == 300) long_hold_req = 1'b1;
      if (n == 700) wait_drained();
      stim = random_quad();
      send_quad(stim, rotate_quad(stim), (n >= 300 && n < 340) ? 0 : draw_wait(send_burst));
    end

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : drain_results
    int  hold;
    int  xfers;
    bit  recv_burst;
    out_stall_i = 1'b0;
    xfers = 0;
    recv_burst = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (xfers % 50 == 0) recv_burst = ($urandom_range(0, 2) == 0);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        hold = draw_wait(recv_burst);
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(negedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      xfers++;
    end
  end

  always @(posedge clk_i) begin : check_corners
    rqcg_out_t want;
    logic [COORD_W-1:0] got_f, want_f;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_corners.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result transfer: %h", out_data_o);
      end else begin
        want = pending_corners.pop_front();
        for (int k = 0; k < 8; k++) begin
          want_f = want[(7 - k) * COORD_W +: COORD_W];
          got_f  = out_data_o[(7 - k) * COORD_W +: COORD_W];
          if (got_f !== want_f) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch %s: expected %0d, got %0d",
                       field_name[k], $signed(want_f), $signed(got_f));
          end
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
